@@ design/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// Shared widths, register indexes and item types for the spiral matrix order
// block.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int VALUE_W   = 32;
    localparam int POS_W     = 3;
    localparam int DIM_W     = 4;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int M_TDATA_W = 40;

    localparam logic [DIM_W-1:0]     DIM_RESET    = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // spiral walker position towards the output side
    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } spm_req_t;

    // one result held in the output buffer
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               last;
    } spm_item_t;

endpackage

@@ design/spm_store.sv @@
// ----------------------------------------------------------------------------
// spm_store
// Matrix element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [spm_pkg::VALUE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [spm_pkg::VALUE_W-1:0] rd_data
);
    import spm_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/spm_walker.sv @@
// ----------------------------------------------------------------------------
// spm_walker
// Clockwise spiral address generator: one matrix position per advance.
// ----------------------------------------------------------------------------
module spm_walker #(
    parameter int AW = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [spm_pkg::DIM_W-1:0] rows,
    input  logic [spm_pkg::DIM_W-1:0] cols,
    input  logic                      advance,
    output spm_pkg::spm_req_t         req,
    output logic [AW-1:0]             rd_addr
);
    import spm_pkg::*;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } dir_t;

    dir_t               dir_reg, dir_next;
    logic               active_reg, active_next;
    logic [DIM_W-1:0]   r_reg, r_next, c_reg, c_next;
    logic [DIM_W-1:0]   rs_reg, rs_next, re_reg, re_next;
    logic [DIM_W-1:0]   cs_reg, cs_next, ce_reg, ce_next;
    logic [DIM_W-1:0]   cols_reg, cols_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [2*DIM_W-1:0] row_base;
    logic [2*DIM_W-1:0] size;

    assign size = rows * cols;

    always_comb begin
        dir_next    = dir_reg;
        active_next = active_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        rs_next     = rs_reg;
        re_next     = re_reg;
        cs_next     = cs_reg;
        ce_next     = ce_reg;
        cols_next   = cols_reg;
        left_next   = left_reg;
        if (start) begin
            active_next = 1'b1;
            dir_next    = DIR_RIGHT;
            r_next      = '0;
            c_next      = '0;
            rs_next     = '0;
            cs_next     = '0;
            re_next     = rows - 1'b1;
            ce_next     = cols - 1'b1;
            cols_next   = cols;
            left_next   = size[COUNT_W-1:0];
        end else if (advance && active_reg) begin
            left_next = left_reg - 1'b1;
            if (left_reg == COUNT_W'(1)) begin
                active_next = 1'b0;
            end
            case (dir_reg)
                DIR_RIGHT: begin
                    if (c_reg == ce_reg) begin
                        rs_next  = rs_reg + 1'b1;
                        r_next   = rs_reg + 1'b1;
                        dir_next = DIR_DOWN;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
                DIR_DOWN: begin
                    if (r_reg == re_reg) begin
                        ce_next  = ce_reg - 1'b1;
                        c_next   = ce_reg - 1'b1;
                        dir_next = DIR_LEFT;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end
                DIR_LEFT: begin
                    if (c_reg == cs_reg) begin
                        re_next  = re_reg - 1'b1;
                        r_next   = re_reg - 1'b1;
                        dir_next = DIR_UP;
                    end else begin
                        c_next = c_reg - 1'b1;
                    end
                end
                DIR_UP: begin
                    if (r_reg == rs_reg) begin
                        cs_next  = cs_reg + 1'b1;
                        c_next   = cs_reg + 1'b1;
                        dir_next = DIR_RIGHT;
                    end else begin
                        r_next = r_reg - 1'b1;
                    end
                end
                default: begin
                    dir_next = DIR_RIGHT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            dir_reg    <= DIR_RIGHT;
        end else begin
            active_reg <= active_next;
            dir_reg    <= dir_next;
        end
        r_reg    <= r_next;
        c_reg    <= c_next;
        rs_reg   <= rs_next;
        re_reg   <= re_next;
        cs_reg   <= cs_next;
        ce_reg   <= ce_next;
        cols_reg <= cols_next;
        left_reg <= left_next;
    end

    assign row_base   = r_reg * cols_reg;
    assign rd_addr    = AW'(row_base + {{DIM_W{1'b0}}, c_reg});
    assign req.active = active_reg;
    assign req.row    = r_reg[POS_W-1:0];
    assign req.col    = c_reg[POS_W-1:0];
    assign req.last   = (left_reg == COUNT_W'(1));

endmodule

@@ design/spiral_matrix_order.sv @@
// ----------------------------------------------------------------------------
// spiral_matrix_order
// Loads a matrix in row-major order and returns it in clockwise spiral order.
//
// Input stream (s_*): one signed 32-bit element per transfer, row-major.
// Output stream (m_*): one element per transfer with its row and column;
// m_tlast marks the final element of the spiral.
// Configuration (cfg_*): index 0 sets num_rows, index 1 sets num_cols; a
// value of 0 acts as 1 and a value above the maximum acts as the maximum.
// Write only while the block is idle.
// The transfer that completes the matrix starts the spiral readout from the
// single store read port: one store read per cycle while the output buffer
// has room, and one result per cycle while the receiver does not stall.
// s_tready stays low while the spiral is being read out.
// A stalled receiver holds the result in the two-entry output buffer and
// pauses the store reads; nothing is dropped.
// Reset clears the load count, the output buffer and sets both sizes to 8;
// store contents are not cleared.
// ----------------------------------------------------------------------------
module spiral_matrix_order #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spm_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] element_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spm_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] out_value, [34:32] out_row,
                                                     // [37:35] out_col, [39:38] zero
    output logic                          m_tlast,   // is_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spm_pkg::DIM_W-1:0]     cfg_data
);
    import spm_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_COLS);

    logic [DIM_W-1:0]   num_rows_reg, num_cols_reg;
    logic [DIM_W-1:0]   rows_eff, cols_eff;
    logic [2*DIM_W-1:0] total;
    logic [COUNT_W-1:0] load_count_reg, load_count_next;
    logic [COUNT_W:0]   count_inc;
    logic               s_accept, complete;

    spm_req_t           req;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               issue, pop;
    logic [1:0]         occupancy;
    logic               rd_valid_reg;
    logic [POS_W-1:0]   rd_row_reg, rd_col_reg;
    logic               rd_last_reg;
    spm_item_t          rd_item;
    logic               head_valid_reg, head_valid_next, skid_valid_reg, skid_valid_next;
    spm_item_t          head_reg, head_next, skid_reg, skid_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= DIM_RESET;
            num_cols_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff = num_rows_reg;
        if (num_rows_reg == '0) begin
            rows_eff = DIM_W'(1);
        end else if (num_rows_reg > MAX_R) begin
            rows_eff = MAX_R;
        end
        cols_eff = num_cols_reg;
        if (num_cols_reg == '0) begin
            cols_eff = DIM_W'(1);
        end else if (num_cols_reg > MAX_C) begin
            cols_eff = MAX_C;
        end
    end

    assign total = rows_eff * cols_eff;

    // load side
    assign s_tready  = !req.active;
    assign s_accept  = s_tvalid && s_tready;
    assign count_inc = (load_count_reg == '1) ? {1'b0, load_count_reg}
                                              : {1'b0, load_count_reg} + 1'b1;
    assign complete  = s_accept && (count_inc >= (COUNT_W+1)'(total));

    always_comb begin
        load_count_next = load_count_reg;
        if (complete) begin
            load_count_next = '0;
        end else if (s_accept) begin
            load_count_next = count_inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
        end else begin
            load_count_reg <= load_count_next;
        end
    end

    spm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (load_count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spm_walker #(
        .AW (AW)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (complete),
        .rows    (rows_eff),
        .cols    (cols_eff),
        .advance (issue),
        .req     (req),
        .rd_addr (rd_addr)
    );

    // read issue: keep reads in flight plus buffered results within two
    assign pop       = head_valid_reg && m_tready;
    assign occupancy = 2'(head_valid_reg) + 2'(skid_valid_reg) + 2'(rd_valid_reg);
    assign issue     = req.active && ((occupancy < 2'd2) || pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
        end
        if (issue) begin
            rd_row_reg  <= req.row;
            rd_col_reg  <= req.col;
            rd_last_reg <= req.last;
        end
    end

    assign rd_item.value = rd_data;
    assign rd_item.row   = rd_row_reg;
    assign rd_item.col   = rd_col_reg;
    assign rd_item.last  = rd_last_reg;

    // output buffer: head register drives the port, skid register behind it
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_next = skid_reg;
                if (rd_valid_reg) begin
                    skid_next = rd_item;
                end else begin
                    skid_valid_next = 1'b0;
                end
            end else if (rd_valid_reg) begin
                head_next = rd_item;
            end else begin
                head_valid_next = 1'b0;
            end
        end else if (rd_valid_reg) begin
            if (!head_valid_reg) begin
                head_next       = rd_item;
                head_valid_next = 1'b1;
            end else begin
                skid_next       = rd_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {2'b00, head_reg.col, head_reg.row, head_reg.value};
    assign m_tlast  = head_reg.last;

    // checks
    a_no_buffer_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_valid_reg && head_valid_reg && skid_valid_reg && !pop))
        else $error("output buffer overflow");

    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry without head entry");

    a_load_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_count_reg < COUNT_W'(DEPTH))
        else $error("load count beyond store depth");

    a_read_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(req.active))
        else $error("store read returned without an active spiral");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for spiral_matrix_order.
//
// Elements stream in row-major order through the s_* channel and the bench
// keeps its own copy of the store, the load count and both size registers.
// Each accepted element may complete a matrix, in which case the whole
// clockwise walk is queued as expected results. Every m_* transfer is checked
// field by field against the oldest expected result. Sizes are rewritten
// between phases while the block is idle, including out-of-range values,
// unused register indexes and a size change with a load partly done. Both
// channels draw random gaps per transfer, with some phases running flat out.
// ----------------------------------------------------------------------------
module tb;
    import spm_pkg::*;

    localparam int MAX_ROWS      = 8;
    localparam int MAX_COLS      = 8;
    localparam int STORE_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int MAX_GAP       = 17;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 360;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    spiral_matrix_order #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bench copy of the block state
    logic [VALUE_W-1:0] matrix_words [STORE_DEPTH];
    int                 load_count = 0;
    logic [DIM_W-1:0]   rows_reg = DIM_RESET;
    logic [DIM_W-1:0]   cols_reg = DIM_RESET;

    logic [VALUE_W-1:0] pending_elements [$];
    spm_item_t          spiral_expected [$];

    int  elements_pushed = 0;
    int  elements_taken = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  s_fire = 1'b0;
    bit  m_fire = 1'b0;
    bit  cfg_fire = 1'b0;
    bit  s_calm = 1'b0;
    bit  m_calm = 1'b0;
    int  s_gap = 0;
    int  m_wait = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int dim_in_use(input logic [DIM_W-1:0] raw, input int max_dim);
        if (raw == 0) return 1;
        if (int'(raw) > max_dim) return max_dim;
        return int'(raw);
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_walk_step(input int r, input int c, input int cols, input bit last);
        spm_item_t item;
        int        idx;
        idx        = r * cols + c;
        item.value = matrix_words[idx[STORE_AW-1:0]];
        item.row   = r[POS_W-1:0];
        item.col   = c[POS_W-1:0];
        item.last  = last;
        spiral_expected.push_back(item);
    endtask

    // store the element and, once the matrix is full, queue its clockwise walk
    task automatic predict_spiral(input logic [VALUE_W-1:0] element);
        int rows, cols, total, n, rs, re, cs, ce, r, c;
        rows  = dim_in_use(rows_reg, MAX_ROWS);
        cols  = dim_in_use(cols_reg, MAX_COLS);
        total = rows * cols;
        if (load_count < STORE_DEPTH) matrix_words[load_count[STORE_AW-1:0]] = element;
        if (load_count < 127) load_count++;
        if (load_count >= total) begin
            n  = 0;
            rs = 0;
            re = rows - 1;
            cs = 0;
            ce = cols - 1;
            while (rs <= re && cs <= ce) begin
                for (c = cs; c <= ce; c++) begin
                    n++;
                    queue_walk_step(rs, c, cols, n == total);
                end
                rs++;
                for (r = rs; r <= re; r++) begin
                    n++;
                    queue_walk_step(r, ce, cols, n == total);
                end
                ce--;
                if (rs <= re) begin
                    for (c = ce; c >= cs; c--) begin
                        n++;
                        queue_walk_step(re, c, cols, n == total);
                    end
                    re--;
                end
                if (cs <= ce) begin
                    for (r = re; r >= rs; r--) begin
                        n++;
                        queue_walk_step(r, cs, cols, n == total);
                    end
                end
                cs++;
            end
            load_count = 0;
        end
    endtask

    task automatic check_result();
        spm_item_t got;
        spm_item_t want;
        got.value = m_tdata[31:0];
        got.row   = m_tdata[34:32];
        got.col   = m_tdata[37:35];
        got.last  = m_tlast;
        if (spiral_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result: value %h row %0d col %0d last %b",
                         got.value, got.row, got.col, got.last);
        end else begin
            want = spiral_expected.pop_front();
            if (got != want || m_tdata[39:38] != 2'b00) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: exp %h r%0d c%0d l%b, got %h r%0d c%0d l%b pad %b",
                             want.value, want.row, want.col, want.last,
                             got.value, got.row, got.col, got.last, m_tdata[39:38]);
            end
        end
    endtask

    always @(posedge aclk) begin
        s_fire   <= aresetn && s_tvalid && s_tready;
        m_fire   <= aresetn && m_tvalid && m_tready;
        cfg_fire <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NUM_ROWS) rows_reg = cfg_data;
                else if (cfg_index == REG_NUM_COLS) cols_reg = cfg_data;
            end
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                elements_taken++;
                predict_spiral(s_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // element sender: hold until transfer, then wait out the drawn gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = draw_gap(s_calm);
        end else if (!s_tvalid || s_fire) begin
            if (s_fire) s_gap = draw_gap(s_calm);
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_elements.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_elements.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall for the drawn count before each transfer
    always @(negedge aclk) begin
        if (m_fire) m_wait = draw_gap(m_calm);
        if (m_wait > 0) begin
            m_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_element(input logic [VALUE_W-1:0] element);
        pending_elements.push_back(element);
        elements_pushed++;
    endtask

    task automatic push_random(input int count);
        repeat (count) push_element(pick_element());
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (elements_taken != elements_pushed || spiral_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int rows_raw, cols_raw, total, partial;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // single row, columns still at reset size
        write_reg(REG_NUM_ROWS, 4'd1);
        push_element(32'h8000_0000);
        push_element(32'h7FFF_FFFF);
        push_element(32'h0000_0000);
        push_element(32'hFFFF_FFFF);
        push_element(32'h5555_5555);
        push_element(32'hAAAA_AAAA);
        push_element(32'h0000_0001);
        push_element(32'hFFFF_FFFE);
        wait_idle();

        // zero sizes act as one
        write_reg(REG_NUM_ROWS, 4'd0);
        write_reg(REG_NUM_COLS, 4'd0);
        push_element(32'h1234_5678);
        wait_idle();

        // single column
        write_reg(REG_NUM_ROWS, 4'd3);
        write_reg(REG_NUM_COLS, 4'd1);
        push_random(3);
        wait_idle();

        // unused indexes are dropped
        write_reg(REG_SPARE_LO, 4'd15);
        write_reg(REG_SPARE_HI, 4'd0);
        write_reg(REG_NUM_ROWS, 4'd2);
        write_reg(REG_NUM_COLS, 4'd3);
        push_random(6);
        wait_idle();

        // shrink with a load partly done
        write_reg(REG_NUM_ROWS, 4'd2);
        write_reg(REG_NUM_COLS, 4'd2);
        push_random(3);
        wait_idle();
        write_reg(REG_NUM_ROWS, 4'd1);
        write_reg(REG_NUM_COLS, 4'd1);
        push_random(1);
        wait_idle();

        // oversize clamps to the maximum
        write_reg(REG_NUM_ROWS, 4'd15);
        write_reg(REG_NUM_COLS, 4'd9);
        push_random(STORE_DEPTH);
        wait_idle();

        partial = 0;
        while (elements_pushed < RANDOM_ITEMS) begin
            s_calm = ($urandom_range(0, 3) == 0);
            m_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: rows_raw = 0;
                1: rows_raw = $urandom_range(9, 15);
                2: rows_raw = 8;
                default: rows_raw = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0: cols_raw = 0;
                1: cols_raw = $urandom_range(9, 15);
                2: cols_raw = 8;
                default: cols_raw = $urandom_range(1, 8);
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          DIM_W'($urandom));
            write_reg(REG_NUM_ROWS, rows_raw[DIM_W-1:0]);
            write_reg(REG_NUM_COLS, cols_raw[DIM_W-1:0]);
            total = dim_in_use(rows_raw[DIM_W-1:0], MAX_ROWS)
                  * dim_in_use(cols_raw[DIM_W-1:0], MAX_COLS);
            // finish any load left over from the last phase
            if (partial > 0 && partial < total) push_random(total - partial);
            else if (partial > 0) push_random(1);
            push_random(total * $urandom_range(1, 3));
            partial = 0;
            if (total > 1 && $urandom_range(0, 4) == 0) begin
                partial = $urandom_range(1, total - 1);
                push_random(partial);
            end
            wait_idle();
        end

        s_calm = 1'b0;
        m_calm = 1'b0;
        write_reg(REG_NUM_ROWS, 4'd8);
        write_reg(REG_NUM_COLS, 4'd8);
        if (partial == 0) push_random(STORE_DEPTH);
        else push_random(STORE_DEPTH - partial);
        wait_idle();

        if (mismatches == 0 && spiral_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/spm_pkg.sv
design/spm_store.sv
design/spm_walker.sv
design/spiral_matrix_order.sv
tb/tb.sv
